// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the accumulator RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define AST_ANY(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AST_CLK(lbl, clk, rst_n, prop)
`define AST_ANY(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/sacc_pkg.sv =====
// Package for the sparse AXPY accumulator: payload structs, command codes, sizes.
// No dependencies.
`default_nettype none
package sacc_pkg;
	localparam int unsigned MaxColumns = 4096;
	localparam int unsigned ColW = $clog2(MaxColumns);
	localparam int unsigned QDepth = 2;

	typedef enum logic [2:0] {
		CMD_SCATTER = 3'd0,
		CMD_PAIR    = 3'd1,
		CMD_SINGLE  = 3'd2,
		CMD_FOLD    = 3'd3,
		CMD_DRAIN   = 3'd4
	} cmd_e;

	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_COLS    = 2'd1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [11:0] col;
		logic [15:0] val_a;
		logic [15:0] val_b;
		logic        line_pick;
		logic [15:0] coef_11;
		logic [15:0] coef_21;
		logic [15:0] coef_12;
		logic [15:0] coef_22;
	} in_beat_t;

	typedef struct packed {
		logic [11:0] col_out;
		logic [15:0] out_a;
		logic [15:0] out_b;
		logic        keep;
		logic        overflow;
	} out_beat_t;

	// classified operation handed from the front to the back part
	typedef struct packed {
		logic [2:0]  cmd;
		logic        live;
		logic [11:0] col;
		logic [15:0] va;
		logic [15:0] vb;
		logic [15:0] c11;
		logic [15:0] c21;
		logic [15:0] c12;
		logic [15:0] c22;
	} op_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sacc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sacc_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sacc_modred.sv =====
// Iterative 64-bit by 16-bit modulo unit, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none
module sacc_modred (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [15:0] p,
	output logic             done,
	output logic [15:0]      rem
);
	logic [63:0] sh_q;
	logic [16:0] r_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [16:0] r_next;
	logic [16:0] r_sub;

	always_comb begin
		r_next = {r_q[15:0], sh_q[63]};
		r_sub = (r_next >= {1'b0, p}) ? r_next - {1'b0, p} : r_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[62:0], 1'b0};
			r_q <= r_sub;
		end
	end
	assign rem = r_q[15:0];
endmodule
`default_nettype wire

// ===== hw/rtl/sacc_front.sv =====
// Front part: accepts input beats, classifies them, pushes ops into a short queue.
// Depends on sacc_pkg.
`default_nettype none
module sacc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sacc_pkg::in_beat_t in_data,
	input  wire logic [12:0]       cols_used,
	output logic                   op_valid,
	input  wire logic              op_pop,
	output sacc_pkg::op_t          op_head
);
	sacc_pkg::op_t q_q [sacc_pkg::QDepth];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;
	logic [12:0] lim;
	sacc_pkg::op_t op_new;

	assign in_stall = (cnt_q == 2'(sacc_pkg::QDepth));
	assign push = in_valid && !in_stall;
	assign lim = (cols_used > 13'(sacc_pkg::MaxColumns)) ? 13'(sacc_pkg::MaxColumns)
		: cols_used;

	always_comb begin
		op_new.cmd = in_data.cmd;
		op_new.col = in_data.col;
		op_new.live = ({1'b0, in_data.col} < lim);
		op_new.va = (in_data.cmd == sacc_pkg::CMD_SINGLE && in_data.line_pick)
			? in_data.val_b : in_data.val_a;
		op_new.vb = in_data.val_b;
		op_new.c11 = in_data.coef_11;
		op_new.c21 = in_data.coef_21;
		op_new.c12 = (in_data.cmd == sacc_pkg::CMD_SINGLE) ? 16'd0 : in_data.coef_12;
		op_new.c22 = (in_data.cmd == sacc_pkg::CMD_SINGLE) ? 16'd0 : in_data.coef_22;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (op_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(op_pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= op_new;
	end
	assign op_valid = (cnt_q != 2'd0);
	assign op_head = q_q[rd_q];
endmodule
`default_nettype wire

// ===== hw/rtl/sacc_back.sv =====
// Back part: read-modify-write of the two accumulator rows with mod-p steps.
// Depends on sacc_pkg, sacc_ram, sacc_modred and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sacc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [15:0]        p,
	input  wire logic               op_valid,
	input  wire sacc_pkg::op_t      op,
	output logic                    op_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sacc_pkg::out_beat_t     out_data
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_RD    = 10'b0000000010,
		ST_NEG   = 10'b0000000100,
		ST_MUL   = 10'b0000001000,
		ST_SUM   = 10'b0000010000,
		ST_MODB  = 10'b0000100000,
		ST_FMUL  = 10'b0001000000,
		ST_MODA  = 10'b0010000000,
		ST_WR    = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} st_t;
	st_t st_q;

	sacc_pkg::op_t op_q;
	logic [63:0] a_q, b_q, pa_q, pb_q, pc_q, pd_q;
	logic [15:0] n_q [4];
	logic [2:0]  nidx_q;
	logic [15:0] ra_q, rb_q;
	logic        ovf_q, started_q;
	sacc_pkg::out_beat_t res_q;
	logic        res_v_q;
	logic        clr_q;
	logic [sacc_pkg::ColW-1:0] clr_idx_q;

	logic [63:0] rd_a, rd_b;
	logic        we, we_op, out_free;
	logic [sacc_pkg::ColW-1:0] wa;
	logic [63:0] wd_a, wd_b;
	logic        md_start, md_done;
	logic [63:0] md_num;
	logic [15:0] md_rem;
	logic [64:0] sum_a, sum_b;
	logic [15:0] cur_c;

	sacc_ram #(.Width(64), .Depth(sacc_pkg::MaxColumns)) u_ram_a (
		.clk, .we, .waddr(wa), .wdata(wd_a), .raddr(op_q.col), .rdata(rd_a));
	sacc_ram #(.Width(64), .Depth(sacc_pkg::MaxColumns)) u_ram_b (
		.clk, .we, .waddr(wa), .wdata(wd_b), .raddr(op_q.col), .rdata(rd_b));
	sacc_modred u_mod (.clk, .arst_n, .start(md_start), .num(md_num), .p(p),
		.done(md_done), .rem(md_rem));

	// zero both rows after reset, one column per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + {{(sacc_pkg::ColW-1){1'b0}}, 1'b1};
			if (&clr_idx_q) clr_q <= 1'b0;
		end
	end

	always_comb begin
		unique case (nidx_q[1:0])
			2'd0: cur_c = op_q.c11;
			2'd1: cur_c = op_q.c21;
			2'd2: cur_c = op_q.c12;
			default: cur_c = op_q.c22;
		endcase
	end

	assign sum_a = {1'b0, a_q} + {1'b0, pa_q + pc_q};
	assign sum_b = {1'b0, b_q} + {1'b0, pb_q + pd_q};
	// the result register may be replaced once its beat leaves
	assign out_free = !res_v_q || !out_stall;
	assign op_pop = (st_q == ST_IDLE) && op_valid && !clr_q;

	always_comb begin
		md_start = 1'b0;
		md_num = {48'd0, cur_c};
		if (st_q == ST_NEG && !started_q) md_start = 1'b1;
		if (st_q == ST_MODB && !started_q) begin
			md_start = 1'b1;
			// a drain starts straight from the row read
			md_num = (op_q.cmd == sacc_pkg::CMD_DRAIN) ? rd_b : b_q;
		end
		if (st_q == ST_MODA && !started_q) begin
			md_start = 1'b1;
			md_num = a_q;
		end
	end

	assign we_op = (st_q == ST_WR) && op_q.live && (op_q.cmd <= sacc_pkg::CMD_DRAIN);
	assign we = clr_q || we_op;
	assign wa = clr_q ? clr_idx_q : op_q.col;
	always_comb begin
		unique case (op_q.cmd)
			sacc_pkg::CMD_SCATTER: begin
				wd_a = {48'd0, op_q.va};
				wd_b = {48'd0, op_q.vb};
			end
			sacc_pkg::CMD_FOLD: begin
				wd_a = {48'd0, ra_q};
				wd_b = {48'd0, rb_q};
			end
			sacc_pkg::CMD_DRAIN: begin
				wd_a = '0;
				wd_b = '0;
			end
			default: begin
				wd_a = a_q;
				wd_b = b_q;
			end
		endcase
		if (clr_q) begin
			wd_a = '0;
			wd_b = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			started_q <= 1'b0;
			nidx_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= (res_v_q && out_stall) || ((st_q == ST_OUT) && out_free);
			unique case (st_q)
				ST_IDLE: if (op_pop) st_q <= ST_RD;
				ST_RD: begin
					nidx_q <= '0;
					started_q <= 1'b0;
					priority if (!op_q.live || op_q.cmd > sacc_pkg::CMD_DRAIN
						|| op_q.cmd == sacc_pkg::CMD_SCATTER)
						st_q <= ST_WR;
					else if (op_q.cmd == sacc_pkg::CMD_DRAIN) st_q <= ST_MODB;
					else st_q <= ST_NEG;
				end
				ST_NEG: begin
					if (!started_q) started_q <= 1'b1;
					else if (md_done) begin
						started_q <= 1'b0;
						nidx_q <= nidx_q + 3'd1;
						if (nidx_q == 3'd3 || (op_q.cmd == sacc_pkg::CMD_FOLD))
							st_q <= (op_q.cmd == sacc_pkg::CMD_FOLD) ? ST_MODB : ST_MUL;
					end
				end
				ST_MUL: st_q <= ST_SUM;
				ST_SUM: st_q <= ST_WR;
				ST_MODB: begin
					if (!started_q) started_q <= 1'b1;
					else if (md_done) begin
						started_q <= 1'b0;
						st_q <= (op_q.cmd == sacc_pkg::CMD_FOLD) ? ST_FMUL : ST_MODA;
					end
				end
				ST_FMUL: st_q <= ST_MODA;
				ST_MODA: begin
					if (!started_q) started_q <= 1'b1;
					else if (md_done) begin
						started_q <= 1'b0;
						st_q <= ST_WR;
					end
				end
				ST_WR: st_q <= ST_OUT;
				ST_OUT: if (out_free) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) op_q <= op;
		unique case (st_q)
			ST_RD: begin
				ovf_q <= 1'b0;
				ra_q <= '0;
				rb_q <= '0;
			end
			ST_NEG: begin
				if (started_q && md_done)
					n_q[nidx_q[1:0]] <= (md_rem == 16'd0) ? 16'd0 : p - md_rem;
			end
			ST_MUL: begin
				pa_q <= 64'(n_q[0] * op_q.va);
				pb_q <= 64'(n_q[1] * op_q.va);
				pc_q <= 64'(n_q[2] * op_q.vb);
				pd_q <= 64'(n_q[3] * op_q.vb);
			end
			ST_SUM: begin
				a_q <= sum_a[63:0];
				b_q <= sum_b[63:0];
				ovf_q <= sum_a[64] | sum_b[64];
			end
			ST_MODB: if (started_q && md_done) begin
				rb_q <= md_rem;
				b_q <= {48'd0, md_rem};
			end
			ST_FMUL: begin
				a_q <= a_q + 64'(n_q[0] * rb_q);
				ovf_q <= ({1'b0, a_q} + {1'b0, 64'(n_q[0] * rb_q)}) > 65'h0FFFFFFFFFFFFFFFF;
			end
			ST_MODA: if (started_q && md_done) ra_q <= md_rem;
			ST_OUT: if (out_free) begin
				res_q.col_out <= (op_q.cmd == sacc_pkg::CMD_DRAIN) ? op_q.col : 12'd0;
				res_q.out_a <= (op_q.cmd == sacc_pkg::CMD_DRAIN) ? ra_q : 16'd0;
				res_q.out_b <= (op_q.cmd == sacc_pkg::CMD_DRAIN) ? rb_q : 16'd0;
				res_q.keep <= (op_q.cmd == sacc_pkg::CMD_DRAIN) && (ra_q != 0 || rb_q != 0);
				res_q.overflow <= ovf_q;
			end
			default: ;
		endcase
		// memory data lands in the cycle after the read address is set
		if (st_q == ST_NEG && !started_q && nidx_q == 3'd0) begin
			a_q <= rd_a;
			b_q <= rd_b;
		end
		if (st_q == ST_MODB && op_q.cmd == sacc_pkg::CMD_DRAIN && !started_q) begin
			a_q <= rd_a;
			b_q <= rd_b;
		end
	end

	assign out_valid = res_v_q;
	assign out_data = res_q;

	`AST_CLK(a_onehot, clk, arst_n, $onehot(st_q))
	`AST_CLK(a_pop_idle, clk, arst_n, op_pop |-> (st_q == ST_IDLE))
	`AST_CLK(a_wr_live, clk, arst_n, we_op |-> op_q.live)
	`AST_CLK(a_clr_idle, clk, arst_n, clr_q |-> (st_q == ST_IDLE))
	`AST_CLK(a_out_hold, clk, arst_n, (res_v_q && out_stall) |=> $stable(res_q))
endmodule
`default_nettype wire

// ===== hw/rtl/sparse_axpy_accumulator_mod_p.sv =====
// Top level of the two-row sparse AXPY accumulator over GF(p): config port and wiring.
// Depends on sacc_pkg, sacc_front and sacc_back.
//
// Each input beat is one command on one column and yields exactly one output beat.
// Rows are held in two 4096 x 64-bit RAMs, which a clearing pass zeroes after reset:
// while it runs the back part takes nothing, so the front queue fills with two beats
// and then stalls the input. A front part classifies beats into a two-entry queue; the
// back part runs a read-modify-write per command. The mod-p unit is a bit-serial
// divider; a reduction is a start, 64 quotient bits and a done. A beat holds the back
// part for four negations, a multiply and a sum on a pair or single-line axpy; one
// negation, two reductions and a multiply-add on a fold; two reductions on a drain; a
// scatter, an unknown command or an unused column skips to the write state. The output
// beat is registered once the result register is free; a beat accepted while the back
// part idles after clearing is taken from the queue in the next cycle. A stalled
// output beat only holds the back part once the next result is ready to replace it.
`default_nettype none
module sparse_axpy_accumulator_mod_p (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sacc_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sacc_pkg::out_beat_t      out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	logic [15:0] modulus_q;
	logic [12:0] cols_q;
	logic [15:0] p_eff;
	logic        op_valid, op_pop;
	sacc_pkg::op_t op_head;

	function automatic logic REG_IDX(input logic [1:0] r);
		REG_IDX = r[0];
	endfunction

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 16'd65521;
			cols_q <= 13'd4096;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_IDX(sacc_pkg::REG_MODULUS)) modulus_q <= pwdata[15:0];
			if (paddr[2] == REG_IDX(sacc_pkg::REG_COLS)) cols_q <= pwdata[12:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDX(sacc_pkg::REG_COLS)) prdata = {19'd0, cols_q};
		else prdata = {16'd0, modulus_q};
	end
	// moduli below two act as two
	assign p_eff = (modulus_q < 16'd2) ? 16'd2 : modulus_q;

	sacc_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.cols_used(cols_q), .op_valid, .op_pop, .op_head);
	sacc_back u_back (.clk, .arst_n, .p(p_eff), .op_valid, .op(op_head), .op_pop,
		.out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire

// ===== test/acc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sparse AXPY accumulator: snoops the register port and both beat channels,
// predicts each output beat and compares. Depends on sacc_pkg.
module acc_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  sacc_pkg::in_beat_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  sacc_pkg::out_beat_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output int                  mismatches,
	output int                  pending
);
	logic [63:0] row_first [sacc_pkg::MaxColumns];
	logic [63:0] row_second [sacc_pkg::MaxColumns];
	logic [15:0] mod_reg;
	logic [12:0] cols_reg;
	sacc_pkg::out_beat_t drain_q [$];
	int          bad;

	function automatic longint unsigned neg_coef(logic [15:0] c, longint unsigned p);
		longint unsigned r;
		r = c % p;
		return (r == 0) ? 0 : p - r;
	endfunction

	// applies one command to the shadow rows and returns its output beat
	function automatic sacc_pkg::out_beat_t accumulate(sacc_pkg::in_beat_t b);
		sacc_pkg::out_beat_t o;
		longint unsigned p, n11, n21, n12, n22, lim, v, old, a, s;
		logic            live, ovf;
		o = '0;
		ovf = 1'b0;
		p = (mod_reg < 2) ? 2 : mod_reg;
		n11 = neg_coef(b.coef_11, p);
		n21 = neg_coef(b.coef_21, p);
		n12 = neg_coef(b.coef_12, p);
		n22 = neg_coef(b.coef_22, p);
		lim = (cols_reg > sacc_pkg::MaxColumns) ? sacc_pkg::MaxColumns : cols_reg;
		live = (b.col < lim);
		case (b.cmd)
			sacc_pkg::CMD_SCATTER: if (live) begin
				row_first[b.col] = b.val_a;
				row_second[b.col] = b.val_b;
			end
			sacc_pkg::CMD_PAIR, sacc_pkg::CMD_SINGLE: if (live) begin
				v = b.line_pick ? b.val_b : b.val_a;
				old = row_first[b.col];
				a = (b.cmd == sacc_pkg::CMD_PAIR) ? n11 * b.val_a + n12 * b.val_b : n11 * v;
				row_first[b.col] = old + a;
				ovf = (row_first[b.col] < old);
				old = row_second[b.col];
				a = (b.cmd == sacc_pkg::CMD_PAIR) ? n21 * b.val_a + n22 * b.val_b : n21 * v;
				row_second[b.col] = old + a;
				ovf = ovf | (row_second[b.col] < old);
			end
			sacc_pkg::CMD_FOLD: if (live) begin
				s = row_second[b.col] % p;
				row_second[b.col] = s;
				old = row_first[b.col];
				a = old + n11 * s;
				ovf = (a < old);
				row_first[b.col] = a % p;
			end
			sacc_pkg::CMD_DRAIN: begin
				o.col_out = b.col;
				if (live) begin
					o.out_a = 16'(row_first[b.col] % p);
					o.out_b = 16'(row_second[b.col] % p);
					o.keep = (o.out_a != 0) || (o.out_b != 0);
					row_first[b.col] = '0;
					row_second[b.col] = '0;
				end
			end
			default: ;
		endcase
		o.overflow = ovf;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sacc_pkg::out_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < sacc_pkg::MaxColumns; i++) begin
				row_first[i] = '0;
				row_second[i] = '0;
			end
			mod_reg = 16'd65521;
			cols_reg = 13'd4096;
			drain_q.delete();
			bad = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (2'(paddr >> 2))
					sacc_pkg::REG_MODULUS: mod_reg = pwdata[15:0];
					sacc_pkg::REG_COLS:    cols_reg = pwdata[12:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (drain_q.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected output beat %p", out_data);
				end else begin
					want = drain_q.pop_front();
					if (want.col_out !== out_data.col_out || want.out_a !== out_data.out_a ||
							want.out_b !== out_data.out_b || want.keep !== out_data.keep ||
							want.overflow !== out_data.overflow) begin
						bad++;
						if (bad <= 10)
							$display({"beat mismatch: exp col %0d a %0d b %0d keep %0b ovf %0b,",
								" got col %0d a %0d b %0d keep %0b ovf %0b"},
								want.col_out, want.out_a, want.out_b, want.keep, want.overflow,
								out_data.col_out, out_data.out_a, out_data.out_b,
								out_data.keep, out_data.overflow);
					end
				end
			end
			if (in_valid && !in_stall)
				drain_q.insert(drain_q.size(), accumulate(in_data));
			mismatches <= bad;
			pending <= drain_q.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the sparse AXPY accumulator testbench: clock, reset, stimulus and verdict.
// Depends on sacc_pkg, sparse_axpy_accumulator_mod_p and acc_checker.
module tb_top;
	localparam int IdleLimit = 20000;	// cycles with no accepted beat before giving up

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	sacc_pkg::in_beat_t  in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	sacc_pkg::out_beat_t out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches, pending;

	// sender / receiver idle rates, in percent
	int          send_gap = 21;
	int          recv_gap = 79;
	logic [12:0] cols_now = 13'd4096;
	int          quiet = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sparse_axpy_accumulator_mod_p dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	acc_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .pending
	);

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_gap);

	// watchdog: counts cycles with no beat and no register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pwrite && pready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IdleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one beat: random gaps first, then hold valid until accepted
	task automatic push_beat(sacc_pkg::in_beat_t b);
		logic stalled;
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		// stall is settled well before the edge that may take the beat
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	// pause the sender until the pipeline is empty, then a little slack
	task automatic drain_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == sacc_pkg::REG_COLS)
			cols_now = val[12:0];
	endtask

	function automatic sacc_pkg::in_beat_t mk(logic [2:0] c, logic [11:0] col,
			logic [15:0] a, logic [15:0] b, logic pick, logic [15:0] k11,
			logic [15:0] k21, logic [15:0] k12, logic [15:0] k22);
		sacc_pkg::in_beat_t t;
		t = '{c, col, a, b, pick, k11, k21, k12, k22};
		return t;
	endfunction

	// coefficients/values lean toward edge cases now and then
	function automatic logic [15:0] pick16();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd65521;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sacc_pkg::in_beat_t rand_beat();
		sacc_pkg::in_beat_t t;
		int          r;
		logic [12:0] lim;
		lim = (cols_now > sacc_pkg::MaxColumns) ? 13'(sacc_pkg::MaxColumns) : cols_now;
		t = '{3'd0, 12'd0, pick16(), pick16(), 1'($urandom), pick16(), pick16(),
			pick16(), pick16()};
		r = $urandom_range(99);
		// mostly the well-formed life of a column: scatter, accumulate, fold, drain
		if (r < 15) t.cmd = sacc_pkg::CMD_SCATTER;
		else if (r < 45) t.cmd = sacc_pkg::CMD_PAIR;
		else if (r < 65) t.cmd = sacc_pkg::CMD_SINGLE;
		else if (r < 80) t.cmd = sacc_pkg::CMD_FOLD;
		else if (r < 95) t.cmd = sacc_pkg::CMD_DRAIN;
		else t.cmd = 3'($urandom_range(7, 5));
		r = $urandom_range(99);
		if (r < 70) t.col = 12'($urandom_range(15));
		else if (r < 85) t.col = 12'($urandom);
		else t.col = 12'(lim + $urandom_range(2) - 1);	// around the in-use edge
		return t;
	endfunction

	initial begin
		logic [15:0] mods [7];
		logic [12:0] colss [7];
		mods  = '{16'd251, 16'd2, 16'd0, 16'd65535, 16'd1, 16'd3, 16'd65521};
		colss = '{13'd4096, 13'd16, 13'd1, 13'd8191, 13'd0, 13'd4095, 13'd4096};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and every command, default registers
		push_beat(mk(sacc_pkg::CMD_PAIR, 12'd5, 16'hFFFF, 16'hFFFF, 0, 16'd1, 16'd2,
			16'd3, 16'd4));	// straight onto the cleared rows
		push_beat(mk(sacc_pkg::CMD_DRAIN, 12'd5, 0, 0, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_FOLD, 12'd6, 0, 0, 0, 16'd9, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_SCATTER, 12'd0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_SCATTER, 12'd4095, 16'd0, 16'd0, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_PAIR, 12'd0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		push_beat(mk(sacc_pkg::CMD_PAIR, 12'd0, 16'hFFFF, 16'd1, 1, 16'd65521, 16'd0, 16'd1,
			16'd65520));
		push_beat(mk(sacc_pkg::CMD_SINGLE, 12'd0, 16'd7, 16'hFFFF, 1, 16'd3, 16'hFFFF, 0, 0));
		push_beat(mk(sacc_pkg::CMD_SINGLE, 12'd4095, 16'hFFFF, 16'd9, 0, 16'h8000, 16'd1,
			0, 0));
		push_beat(mk(sacc_pkg::CMD_FOLD, 12'd0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_FOLD, 12'd4095, 0, 0, 0, 16'd0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_DRAIN, 12'd0, 0, 0, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_DRAIN, 12'd0, 0, 0, 0, 0, 0, 0, 0));	// cleared: keep low
		push_beat(mk(sacc_pkg::CMD_DRAIN, 12'd4095, 0, 0, 0, 0, 0, 0, 0));
		push_beat(mk(3'd5, 12'd1, 16'd1, 16'd1, 1, 16'd1, 16'd1, 16'd1, 16'd1));
		push_beat(mk(3'd7, 12'hFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		drain_wait();

		// small in-use width: beats past it must leave the rows alone
		reg_write(sacc_pkg::REG_COLS, 32'd4);
		reg_write(sacc_pkg::REG_MODULUS, 32'd0);
		push_beat(mk(sacc_pkg::CMD_SCATTER, 12'd4095, 16'd5, 16'd6, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_PAIR, 12'd4, 16'd5, 16'd6, 0, 16'd1, 16'd1, 16'd1, 16'd1));
		push_beat(mk(sacc_pkg::CMD_DRAIN, 12'd4, 0, 0, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_SCATTER, 12'd3, 16'd5, 16'd6, 0, 0, 0, 0, 0));
		push_beat(mk(sacc_pkg::CMD_PAIR, 12'd3, 16'd5, 16'd6, 0, 16'd1, 16'd3, 16'd2, 16'd1));
		push_beat(mk(sacc_pkg::CMD_DRAIN, 12'd3, 0, 0, 0, 0, 0, 0, 0));
		drain_wait();

		// random phases, one register setting each; idle mix changes after phases 1 and 3
		for (int ph = 0; ph < 7; ph++) begin
			if (ph < 2) begin
				send_gap = 21;
				recv_gap = 79;
			end else if (ph < 4) begin
				send_gap = 79;
				recv_gap = 21;
			end else begin
				send_gap = 0;
				recv_gap = 0;
			end
			reg_write(sacc_pkg::REG_MODULUS, 32'(mods[ph]));
			reg_write(sacc_pkg::REG_COLS, 32'(colss[ph]));
			for (int n = 0; n < 250; n++)
				push_beat(rand_beat());
			drain_wait();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sacc_pkg.sv
hw/rtl/sacc_ram.sv
hw/rtl/sacc_modred.sv
hw/rtl/sacc_front.sv
hw/rtl/sacc_back.sv
hw/rtl/sparse_axpy_accumulator_mod_p.sv
test/acc_checker.sv
test/tb_top.sv
